// File: design/wf3_pkg.sv
`timescale 1ns / 1ps

package wf3_pkg;

    typedef struct packed {
        logic [7:0] sample;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  value;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [1:0]  out_channel;
    } out_item_t;

    localparam logic [1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [1:0] MODE_BLUR    = 2'd0;
    localparam logic [1:0] MODE_SHARPEN = 2'd1;

    localparam int WIDTH_LIMIT = 4096;
    localparam logic [11:0] ROW_LIMIT = 12'd4095;
    localparam logic [20:0] SAT_SQUARE = 21'd65025;

endpackage

// File: design/wf3_ram.sv
`timescale 1ns / 1ps

module wf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/wf3_sobel.sv
`timescale 1ns / 1ps

module wf3_sobel (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [9:0] ax,
    input  logic [9:0] ay,
    output logic       done,
    output logic [7:0] mag
);
    import wf3_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_RT   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [9:0]  ax_reg, ay_reg;
    logic [19:0] sqx_reg, sqy_reg;
    logic [7:0]  res_reg, res_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [20:0] n;
    logic [7:0]  trial;
    logic [15:0] trial_sq;

    assign n        = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign trial    = res_reg | (8'd1 << cnt_reg);
    assign trial_sq = trial * trial;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                res_next   = 8'd0;
                cnt_next   = 3'd7;
                state_next = S_RT;
            end
            S_RT:
            begin
                if (n >= SAT_SQUARE)
                begin
                    res_next   = 8'd255;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // one root bit a cycle, msb first
                    if (trial_sq <= n[15:0])
                    begin
                        res_next = trial;
                    end
                    if (cnt_reg == 3'd0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            ax_reg <= ax;
            ay_reg <= ay;
        end
        if (state_reg == S_SQ)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end
        res_reg <= res_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign mag  = res_reg;

endmodule

// File: design/window_filter_3x3.sv
`timescale 1ns / 1ps

// 3x3 window filter over a raster stream of interleaved 8-bit components
// (gaussian blur, clamped sharpen or sobel magnitude). Items are handled one
// at a time: for blur and sharpen an accepted item passes through the read
// of line store and window memory, update and filter, and hand-off to the
// output register; sobel adds the squaring stage and a bit-serial square root
// that yields one root bit per cycle, and a magnitude that saturates at 255
// skips the root. Border positions give no result. A full output register
// holds a finished result back until it drains. A waiting result blocks the
// next item from being accepted. Line stores and per-channel window state sit
// in two synchronous memories with no clearing pass; frame_start restarts the
// position counters only.
module window_filter_3x3 #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wf3_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wf3_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import wf3_pkg::*;

    localparam int LDEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int WAW    = $clog2(MAX_CHANNELS > 1 ? MAX_CHANNELS : 2);
    localparam int XAW    = $clog2(MAX_WIDTH);
    localparam logic [1:0]  CH_MASK  = 2'(MAX_CHANNELS - 1);
    localparam logic [15:0] MAXW     = 16'(MAX_WIDTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_SOB  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    logic [1:0]  mode_reg;
    logic [12:0] width_reg;
    logic [2:0]  chans_reg;

    logic [2:0]  state_reg, state_next;
    logic [11:0] col_reg, row_reg;
    logic [1:0]  comp_reg;

    logic [11:0] col, row;
    logic [1:0]  comp, ch;
    logic [XAW-1:0] xi;
    logic [LAW-1:0] idx;
    logic [12:0] effw;
    logic [2:0]  effc;
    logic        accept;

    logic [7:0]     s_reg;
    logic [1:0]     ch_reg;
    logic [LAW-1:0] idx_reg;
    logic           prod_reg;
    logic [11:0]    ox_reg, oy_reg;
    logic [7:0]     val_reg;
    logic           out_valid_reg;
    out_item_t      out_data_reg;

    logic [15:0] line_rd;
    logic [47:0] win_rd;
    logic [9:0]  a, b, c, d, e, f, g, h, i;
    logic [11:0] blur;
    logic signed [12:0] sharp;
    logic signed [12:0] gx, gy;
    logic [9:0]  ax, ay;
    logic [7:0]  simple_val;
    logic        sob_start, sob_done;
    logic [7:0]  sob_mag;

    // effective limits
    always_comb
    begin
        effw = width_reg;
        if (width_reg == 13'd0)
        begin
            effw = 13'd1;
        end
        if ({3'd0, effw} > MAXW)
        begin
            effw = MAXW[12:0];
        end
        if (effw > 13'(WIDTH_LIMIT))
        begin
            effw = 13'(WIDTH_LIMIT);
        end
        effc = chans_reg;
        if (chans_reg == 3'd0)
        begin
            effc = 3'd1;
        end
        if (effc > 3'(MAX_CHANNELS))
        begin
            effc = 3'(MAX_CHANNELS);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign col  = in_data.frame_start ? 12'd0 : col_reg;
    assign row  = in_data.frame_start ? 12'd0 : row_reg;
    assign comp = in_data.frame_start ? 2'd0 : comp_reg;
    assign ch   = comp & CH_MASK;

    always_comb
    begin
        if ({4'd0, col} >= MAXW)
        begin
            xi = XAW'(MAX_WIDTH - 1);
        end
        else
        begin
            xi = XAW'(col);
        end
    end

    assign idx = LAW'(xi * MAX_CHANNELS) + LAW'(ch);

    // window taps: stored word holds the two right-hand columns of last time
    assign a = {2'd0, win_rd[47:40]};
    assign b = {2'd0, win_rd[39:32]};
    assign c = {2'd0, line_rd[15:8]};
    assign d = {2'd0, win_rd[31:24]};
    assign e = {2'd0, win_rd[23:16]};
    assign f = {2'd0, line_rd[7:0]};
    assign g = {2'd0, win_rd[15:8]};
    assign h = {2'd0, win_rd[7:0]};
    assign i = {2'd0, s_reg};

    assign blur  = 12'(a) + 12'(c) + 12'(g) + 12'(i)
                 + ((12'(b) + 12'(d) + 12'(f) + 12'(h)) << 1) + (12'(e) << 2);
    assign sharp = 13'(e) * 13'sd5 - 13'(b) - 13'(d) - 13'(f) - 13'(h);
    assign gx    = (13'(c) + (13'(f) << 1) + 13'(i)) - (13'(a) + (13'(d) << 1) + 13'(g));
    assign gy    = (13'(g) + (13'(h) << 1) + 13'(i)) - (13'(a) + (13'(b) << 1) + 13'(c));
    assign ax    = gx[12] ? 10'(-gx) : gx[9:0];
    assign ay    = gy[12] ? 10'(-gy) : gy[9:0];

    always_comb
    begin
        if (mode_reg == MODE_BLUR)
        begin
            simple_val = blur[11:4];
        end
        else if (sharp < 0)
        begin
            simple_val = 8'd0;
        end
        else if (sharp > 13'sd255)
        begin
            simple_val = 8'd255;
        end
        else
        begin
            simple_val = sharp[7:0];
        end
    end

    assign sob_start = (state_reg == ST_RD) && prod_reg
                    && mode_reg != MODE_BLUR && mode_reg != MODE_SHARPEN;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (!prod_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (sob_start)
                begin
                    state_next = ST_SOB;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SOB:
            begin
                if (sob_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= 12'd0;
            row_reg       <= 12'd0;
            comp_reg      <= 2'd0;
            mode_reg      <= MODE_BLUR;
            width_reg     <= 13'd640;
            chans_reg     <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FILTER_MODE:   mode_reg  <= cfg_data[1:0];
                    CFG_IMAGE_WIDTH:   width_reg <= cfg_data;
                    CFG_CHANNEL_COUNT: chans_reg <= cfg_data[2:0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                if ({1'b0, comp} + 3'd1 >= effc)
                begin
                    comp_reg <= 2'd0;
                    if ({1'b0, col} + 13'd1 >= effw)
                    begin
                        col_reg <= 12'd0;
                        if (row < ROW_LIMIT)
                        begin
                            row_reg <= row + 12'd1;
                        end
                        else
                        begin
                            row_reg <= row;
                        end
                    end
                    else
                    begin
                        col_reg <= col + 12'd1;
                        row_reg <= row;
                    end
                end
                else
                begin
                    comp_reg <= comp + 2'd1;
                    col_reg  <= col;
                    row_reg  <= row;
                end
            end
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg    <= in_data.sample;
            ch_reg   <= ch;
            idx_reg  <= idx;
            prod_reg <= (row >= 12'd2) && (col >= 12'd2);
            ox_reg   <= col - 12'd1;
            oy_reg   <= row - 12'd1;
        end
        if (state_reg == ST_RD)
        begin
            val_reg <= simple_val;
        end
        if (state_reg == ST_SOB && sob_done)
        begin
            val_reg <= sob_mag;
        end
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            out_data_reg.value       <= val_reg;
            out_data_reg.out_x       <= ox_reg;
            out_data_reg.out_y       <= oy_reg;
            out_data_reg.out_channel <= ch_reg;
        end
    end

    wf3_ram #(
        .WIDTH (16),
        .DEPTH (LDEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (idx_reg),
        .wdata ({line_rd[7:0], s_reg}),
        .raddr (idx),
        .rdata (line_rd)
    );

    wf3_ram #(
        .WIDTH (48),
        .DEPTH (MAX_CHANNELS)
    ) u_win_ram (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (WAW'(ch_reg)),
        .wdata ({b[7:0], c[7:0], e[7:0], f[7:0], h[7:0], s_reg}),
        .raddr (WAW'(ch)),
        .rdata (win_rd)
    );

    wf3_sobel u_sobel (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sob_start),
        .ax    (ax),
        .ay    (ay),
        .done  (sob_done),
        .mag   (sob_mag)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: dv/tb_window_filter_3x3.sv
`timescale 1ns / 1ps

module tb_window_filter_3x3;
    import wf3_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int ITEM_TARGET   = 1550;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    window_filter_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]  line_up  [WIDTH_LIMIT*4];
    logic [7:0]  line_mid [WIDTH_LIMIT*4];
    logic [7:0]  win_regs [36];
    int unsigned col_pos, row_pos, comp_pos;
    logic [1:0]  mode_reg;
    logic [12:0] width_reg;
    logic [2:0]  chan_reg;

    out_item_t pending_pixels[$];
    int        mismatches;
    int        results_seen;
    int        items_sent;
    int        cycles;
    bit        calm;
    int        mode_hits[4];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_pixels.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else
            out_ready = calm || ($urandom_range(99) >= 23);
    end

    function automatic logic [7:0] root_floor(int unsigned n);
        logic [7:0] r;
        r = 8'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if ((int'(r | (8'd1 << b)) * int'(r | (8'd1 << b))) <= n)
                r = r | (8'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [7:0] filter_pixel(int base);
        int a, b, c, d, e, f, g, h, i;
        int s, gx, gy;
        int unsigned n;
        a = win_regs[base];     b = win_regs[base + 1]; c = win_regs[base + 2];
        d = win_regs[base + 3]; e = win_regs[base + 4]; f = win_regs[base + 5];
        g = win_regs[base + 6]; h = win_regs[base + 7]; i = win_regs[base + 8];
        if (mode_reg == MODE_BLUR)
        begin
            s = a + 2*b + c + 2*d + 4*e + 2*f + g + 2*h + i;
            return s[11:4];
        end
        if (mode_reg == MODE_SHARPEN)
        begin
            s = 5*e - b - d - f - h;
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            return s[7:0];
        end
        // mode three falls through to sobel
        gx = (c + 2*f + i) - (a + 2*d + g);
        gy = (g + 2*h + i) - (a + 2*b + c);
        n = gx*gx + gy*gy;
        if (n >= SAT_SQUARE) return 8'd255;
        return root_floor(n);
    endfunction

    task automatic advance_window(input in_item_t it);
        int unsigned x, ch, idx, eff_w, eff_c, base;
        out_item_t   px;
        if (it.frame_start)
        begin
            col_pos = 0; row_pos = 0; comp_pos = 0;
        end
        x = col_pos;
        ch = comp_pos & 3;
        if (x >= WIDTH_LIMIT) x = WIDTH_LIMIT - 1;
        idx = x * 4 + ch;
        base = ch * 9;
        win_regs[base]     = win_regs[base + 1];
        win_regs[base + 1] = win_regs[base + 2];
        win_regs[base + 2] = line_up[idx];
        win_regs[base + 3] = win_regs[base + 4];
        win_regs[base + 4] = win_regs[base + 5];
        win_regs[base + 5] = line_mid[idx];
        win_regs[base + 6] = win_regs[base + 7];
        win_regs[base + 7] = win_regs[base + 8];
        win_regs[base + 8] = it.sample;
        line_up[idx]  = line_mid[idx];
        line_mid[idx] = it.sample;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            px.value       = filter_pixel(base);
            px.out_x       = 12'(col_pos - 1);
            px.out_y       = 12'(row_pos - 1);
            px.out_channel = 2'(ch);
            pending_pixels.push_back(px);
            mode_hits[mode_reg]++;
        end
        eff_w = (width_reg == 0) ? 1 : width_reg;
        if (eff_w > WIDTH_LIMIT) eff_w = WIDTH_LIMIT;
        eff_c = (chan_reg == 0) ? 1 : chan_reg;
        if (eff_c > 4) eff_c = 4;
        if (comp_pos + 1 >= eff_c)
        begin
            comp_pos = 0;
            if (col_pos + 1 >= eff_w)
            begin
                col_pos = 0;
                if (row_pos < ROW_LIMIT) row_pos++;
            end
            else
            begin
                col_pos++;
            end
        end
        else
        begin
            comp_pos++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value %0d x %0d y %0d ch %0d",
                             out_data.value, out_data.out_x, out_data.out_y,
                             out_data.out_channel);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_data.value !== want.value || out_data.out_x !== want.out_x ||
                    out_data.out_y !== want.out_y ||
                    out_data.out_channel !== want.out_channel)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d@(%0d,%0d,%0d) got %0d@(%0d,%0d,%0d)",
                                 want.value, want.out_x, want.out_y, want.out_channel,
                                 out_data.value, out_data.out_x, out_data.out_y,
                                 out_data.out_channel);
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] smp, input logic fs);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.sample = smp;
        in_data.frame_start = fs;
        do @(posedge clk); while (!in_ready);
        advance_window(in_data);
        items_sent++;
    endtask

    // drains the block fully, covers items still in flight with no result
    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FILTER_MODE:   mode_reg  = val[1:0];
            CFG_IMAGE_WIDTH:   width_reg = val;
            CFG_CHANNEL_COUNT: chan_reg  = val[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(input logic [1:0] m, input logic [12:0] w, input logic [2:0] c);
        drain();
        write_reg(CFG_FILTER_MODE, 13'(m));
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_CHANNEL_COUNT, 13'(c));
    endtask

    function automatic logic [7:0] extreme_byte();
        return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    endfunction

    // tiny 3-wide image, then one more row per filter mode
    task automatic test_directed;
        setup(MODE_BLUR, 13'd3, 3'd1);
        for (int k = 0; k < 9; k++) send_item(8'd255, k == 0);
        for (int m = 1; m < 4; m++)
        begin
            drain();
            write_reg(CFG_FILTER_MODE, 13'(m));
            for (int k = 0; k < 3; k++) send_item(extreme_byte(), 1'b0);
        end
    endtask

    task automatic test_config_limits;
        setup(MODE_SHARPEN, 13'd0, 3'd0);
        for (int k = 0; k < 6; k++) send_item(8'($urandom), k == 0);
        setup(MODE_BLUR, 13'd8191, 3'd7);
        for (int k = 0; k < 8; k++) send_item(8'($urandom), k == 0);
        setup(MODE_SHARPEN, 13'd4096, 3'd4);
        for (int k = 0; k < 8; k++) send_item(8'($urandom), k == 0);
        // four channels on a narrow image, all sharpen edge values
        setup(MODE_SHARPEN, 13'd3, 3'd4);
        for (int k = 0; k < 48; k++) send_item(extreme_byte(), k == 0);
    endtask

    task automatic test_random_frames;
        int rows, w, c, total, cut;
        logic [12:0] wsel;
        logic [2:0]  csel;
        while (items_sent < ITEM_TARGET)
        begin
            w = $urandom_range(3, 10);
            if ($urandom_range(9) == 0) w = $urandom_range(1, 2);
            if ($urandom_range(14) == 0) w = 40;
            c = $urandom_range(1, 4);
            wsel = 13'(w);
            csel = 3'(c);
            if ($urandom_range(11) == 0) csel = 3'($urandom_range(5, 7));
            if ($urandom_range(11) == 0) csel = 3'd0;
            if (csel == 0 || csel > 4) c = (csel == 0) ? 1 : 4;
            setup(2'($urandom_range(3)), wsel, csel);
            calm = ($urandom_range(7) == 0);
            rows = $urandom_range(3, 5);
            total = w * c * rows;
            // a few frames are cut short and restarted part-way
            cut = ($urandom_range(5) == 0) ? $urandom_range(1, total - 1) : -1;
            for (int k = 0; k < total; k++)
            begin
                logic [7:0] smp;
                smp = ($urandom_range(7) == 0) ? extreme_byte() : 8'($urandom);
                send_item(smp, k == 0 || k == cut);
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FILTER_MODE;
        cfg_data = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        for (int k = 0; k < 4; k++) mode_hits[k] = 0;
        for (int k = 0; k < WIDTH_LIMIT*4; k++)
        begin
            line_up[k] = '0;
            line_mid[k] = '0;
        end
        for (int k = 0; k < 36; k++) win_regs[k] = '0;
        col_pos = 0; row_pos = 0; comp_pos = 0;
        mode_reg = MODE_BLUR; width_reg = 13'd640; chan_reg = 3'd1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_limits();
        test_random_frames();
        drain();

        $display("%0d items in, %0d filtered pixels checked", items_sent, results_seen);
        $display("per mode blur %0d sharpen %0d sobel %0d mode3 %0d, incl. limits",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_pixels.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
